[rtl/core/fhp_pkg.sv]
// Shared constants, types and phase/kind codes of the frequency header parser.
`default_nettype none
package fhp_pkg;

    localparam int NUMBER_BITS = 31;

    localparam logic [7:0] SEP_NUMBER = 8'h5F;
    localparam logic [7:0] SEP_ENTRY  = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [2:0] PH_TOTAL   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_COUNT   = 3'd2;
    localparam logic [2:0] PH_SYM     = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [2:0] K_CONSUMED = 3'd0;
    localparam logic [2:0] K_TOTAL    = 3'd1;
    localparam logic [2:0] K_LEN      = 3'd2;
    localparam logic [2:0] K_COUNT    = 3'd3;
    localparam logic [2:0] K_ENTRY    = 3'd4;
    localparam logic [2:0] K_DONE     = 3'd5;
    localparam logic [2:0] K_PAYLOAD  = 3'd6;
    localparam logic [2:0] K_ERROR    = 3'd7;

    typedef struct packed {
        logic [2:0]             phase;
        logic [NUMBER_BITS-1:0] acc;
        logic                   digit_seen;
        logic                   lead_open;
        logic [NUMBER_BITS-1:0] tbl_left;
        logic [NUMBER_BITS-1:0] ent_left;
        logic [30:0]            ent_cnt;
        logic [7:0]             cur_sym;
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [7:0]  symbol;
        logic [30:0] entry_index;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_TOTAL,
        acc:        '0,
        digit_seen: 1'b0,
        lead_open:  1'b0,
        tbl_left:   '0,
        ent_left:   '0,
        ent_cnt:    '0,
        cur_sym:    '0
    };

endpackage
`default_nettype wire

[rtl/core/fhp_if.sv]
// Valid/ready channel interfaces for the parser's byte input and result output.
`default_nettype none
interface fhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source(output valid, output data_byte, output stream_end, input ready);
    modport sink(input valid, input data_byte, input stream_end, output ready);
endinterface

interface fhp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         symbol;
    logic [30:0]        entry_index;

    modport source(output valid, output kind, output value, output symbol,
                   output entry_index, input ready);
    modport sink(input valid, input kind, input value, input symbol,
                 input entry_index, output ready);
endinterface
`default_nettype wire

[rtl/core/frequency_header_parser.sv]
// Top level of the frequency header parser: state register and output buffering.
//
// The block takes one stream byte per item on i_in (data_byte, plus stream_end
// when no byte is left) and gives exactly one result item on o_out for every
// byte it takes: kind, value, symbol and entry_index. It parses the three
// '_'-ended header numbers, reports each table entry, flags header completion
// and then passes every later byte on as payload. Any fault latches the error
// kind until reset.
//
// Each result is registered, in the result register or, while one waits, in
// the skid register. Throughput is one item per cycle while the skid register
// is free; the whole decision for a byte (digit test, times-ten accumulate and
// counter updates) lies between the parser state and result registers.
//
// A two-entry output buffer (result register plus skid register) lets the
// block take another byte while a result waits. When the receiver stalls, the
// skid register fills and i_in.ready drops until the receiver takes a result.
//
// Synchronous active-low reset returns the parser to reading the total count
// with all counters cleared and drops both output entries.
`default_nettype none
module frequency_header_parser
    import fhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    fhp_in_if.sink    i_in,
    fhp_out_if.source o_out
);

    t_state  r_state;
    t_state  n_state;
    t_result step_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;
    logic    in_fire;
    logic    out_fire;

    fhp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.data_byte),
        .i_end    (i_in.stream_end),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // Input is open as long as the skid entry is free.
    assign i_in.ready = !r_skid_vld;
    assign in_fire    = i_in.valid && !r_skid_vld;
    assign out_fire   = r_out_vld && o_out.ready;

    // The parser state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_vld) begin
                r_skid_vld <= 1'b0;
            end else if (!in_fire) begin
                r_out_vld <= 1'b0;
            end
        end else if (!r_out_vld) begin
            r_out_vld <= in_fire;
        end else if (in_fire) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= step_res;
            end
        end else if (!r_out_vld) begin
            if (in_fire) begin
                r_out <= step_res;
            end
        end else if (in_fire) begin
            r_skid <= step_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.kind        = r_out.kind;
    assign o_out.value       = r_out.value;
    assign o_out.symbol      = r_out.symbol;
    assign o_out.entry_index = r_out.entry_index;

endmodule
`default_nettype wire

[rtl/core/fhp_step.sv]
// Next-state and result logic for one stream byte of the header parser.
`default_nettype none
module fhp_step
    import fhp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_state     o_state,
    output t_result    o_result
);

    localparam int SUM_W = NUMBER_BITS + 4;

    logic             is_dig;
    logic [7:0]       b_off;
    logic [3:0]       dval;
    logic [SUM_W-1:0] acc_w;
    logic [SUM_W-1:0] sum;
    logic             ovf;
    logic             err;
    logic             closed;
    logic [31:0]      num32;
    logic [31:0]      acc32;
    logic [NUMBER_BITS-1:0] tl;

    assign is_dig = (i_byte inside {[CH_ZERO:CH_NINE]});
    assign b_off  = i_byte - CH_ZERO;
    assign dval   = b_off[3:0];
    assign acc_w  = {4'b0000, i_state.acc};
    // Times ten as two shifted copies, plus the new digit.
    assign sum    = (acc_w << 3) + (acc_w << 1) + {{NUMBER_BITS{1'b0}}, dval};
    assign ovf    = |sum[SUM_W-1:NUMBER_BITS];
    assign acc32  = {{(32-NUMBER_BITS){1'b0}}, i_state.acc};
    assign num32  = acc32;
    assign tl     = i_state.tbl_left - NUMBER_BITS'(1);

    always_comb begin
        o_state  = i_state;
        o_result = '{kind: K_CONSUMED, value: '0, symbol: '0, entry_index: '0};
        err      = 1'b0;
        closed   = 1'b0;
        case (i_state.phase)
            PH_PAYLOAD: begin
                if (!i_end) begin
                    o_result.kind  = K_PAYLOAD;
                    o_result.value = {24'd0, i_byte};
                end
            end
            PH_TOTAL, PH_LEN, PH_COUNT: begin
                if (i_end) begin
                    err = 1'b1;
                end else if (i_byte != SEP_NUMBER) begin
                    if (!is_dig || ovf) begin
                        err = 1'b1;
                    end else begin
                        o_state.acc        = sum[NUMBER_BITS-1:0];
                        o_state.digit_seen = 1'b1;
                    end
                end else if (!i_state.digit_seen) begin
                    err = 1'b1;
                end else begin
                    o_state.acc        = '0;
                    o_state.digit_seen = 1'b0;
                    if (i_state.phase == PH_TOTAL) begin
                        o_state.phase  = PH_LEN;
                        o_result.kind  = K_TOTAL;
                        o_result.value = num32 - 32'd1;
                    end else if (i_state.phase == PH_LEN) begin
                        o_state.tbl_left = i_state.acc;
                        o_state.phase    = PH_COUNT;
                        o_result.kind    = K_LEN;
                        o_result.value   = num32;
                    end else begin
                        o_state.ent_left = i_state.acc;
                        o_state.ent_cnt  = '0;
                        if (i_state.tbl_left == '0) begin
                            // An empty table is legal only with no entries.
                            if (i_state.acc != '0) begin
                                err = 1'b1;
                            end else begin
                                o_state.phase  = PH_PAYLOAD;
                                o_result.kind  = K_DONE;
                                o_result.value = '1;
                            end
                        end else begin
                            o_state.phase  = PH_SYM;
                            o_result.kind  = K_COUNT;
                            o_result.value = num32;
                        end
                    end
                end
            end
            PH_SYM, PH_DIGITS: begin
                if (i_end || i_state.tbl_left == '0) begin
                    err = 1'b1;
                end else begin
                    o_state.tbl_left = tl;
                    if (i_state.phase == PH_SYM) begin
                        if (i_state.ent_left != '0) begin
                            o_state.cur_sym    = i_byte;
                            o_state.digit_seen = 1'b0;
                            o_state.lead_open  = 1'b0;
                            o_state.acc        = '0;
                            o_state.phase      = PH_DIGITS;
                        end
                    end else if (!i_state.digit_seen) begin
                        if (!is_dig) begin
                            err = 1'b1;
                        end else begin
                            o_state.acc        = {{(NUMBER_BITS-4){1'b0}}, dval};
                            o_state.digit_seen = 1'b1;
                            o_state.lead_open  = 1'b1;
                        end
                    end else if (i_byte == SEP_ENTRY) begin
                        closed             = 1'b1;
                        o_state.ent_cnt    = i_state.ent_cnt + 31'd1;
                        o_state.ent_left   = i_state.ent_left - NUMBER_BITS'(1);
                        o_state.digit_seen = 1'b0;
                        o_state.lead_open  = 1'b0;
                        o_state.acc        = '0;
                        o_state.phase      = PH_SYM;
                    end else if (is_dig && i_state.lead_open) begin
                        if (ovf) begin
                            err = 1'b1;
                        end else begin
                            o_state.acc = sum[NUMBER_BITS-1:0];
                        end
                    end else begin
                        // Bytes after the leading digits are skipped up to the comma.
                        o_state.lead_open = 1'b0;
                    end

                    if (closed) begin
                        o_result.value       = acc32;
                        o_result.symbol      = i_state.cur_sym;
                        o_result.entry_index = i_state.ent_cnt;
                    end
                    if (tl == '0) begin
                        if (o_state.ent_left != '0) begin
                            err = 1'b1;
                        end else begin
                            o_state.phase = PH_PAYLOAD;
                            o_result.kind = K_DONE;
                            if (!closed) begin
                                o_result.value = '1;
                            end
                        end
                    end else if (closed) begin
                        o_result.kind = K_ENTRY;
                    end
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (err) begin
            o_state.phase = PH_ERROR;
            o_result = '{kind: K_ERROR, value: '0, symbol: '0, entry_index: '0};
        end
    end

endmodule
`default_nettype wire

[test/frequency_header_parser_tb.sv]
`timescale 1ns / 100ps
// Testbench for the frequency header parser: framed byte streams checked against a predictor.

module frequency_header_parser_tb;
    import fhp_pkg::*;

    // Largest number the parser may hold, and the rough length of one run in items.
    localparam longint unsigned NUM_LIMIT = (64'd1 << NUMBER_BITS) - 64'd1;
    localparam int STREAM_ITEMS = 900;

    // Reset is applied only once, so a run can walk through only one header. An
    // error also latches until reset. Each run therefore picks one fault, or none.
    // The seed decides which one, and across seeds every fault gets its turn.
    typedef enum int {
        FLT_NONE,
        FLT_BAD_HEADER_BYTE,
        FLT_EMPTY_NUMBER,
        FLT_HEADER_OVERFLOW,
        FLT_HEADER_END,
        FLT_EMPTY_TABLE_COUNT,
        FLT_ENTRY_NO_DIGIT,
        FLT_ENTRY_OVERFLOW,
        FLT_TABLE_OVERRUN,
        FLT_OPEN_ENTRY_OVERRUN,
        FLT_TABLE_END
    } fault_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fhp_in_if  in_ch();
    fhp_out_if out_ch();

    frequency_header_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Parser state as the predictor tracks it.
    logic [2:0]             prs_phase;
    logic [NUMBER_BITS-1:0] acc_num;
    logic                   has_digit;
    logic                   lead_run;
    logic [NUMBER_BITS-1:0] tbl_bytes;
    logic [NUMBER_BITS-1:0] ent_pending;
    logic [30:0]            ent_reported;
    logic [7:0]             sym_hold;

    // Results still owed by the block, oldest first.
    t_result expected_q[$];

    // The planned frequency table, and what the header will announce for it.
    logic [7:0]      tbl_q[$];
    longint unsigned decl_len;
    longint unsigned decl_count;
    int              entries_planned;
    int              end_at;
    fault_e          fault;

    int burst_left;
    int items_sent;
    int err_count;
    int results_checked;
    int kind_tally[8];

    // Receiver back-pressure state.
    int          rx_mode;
    int          rx_left;
    logic [31:0] rx_pattern;

    // Any fault sends the parser into its error phase for good.
    function automatic t_result latch_fault();
        t_result r;

        r         = '0;
        r.kind    = K_ERROR;
        prs_phase = PH_ERROR;
        return r;
    endfunction

    // Works out the result of one accepted byte and advances the predicted state.
    function automatic t_result parse_byte(input logic [7:0] b, input logic at_end);
        t_result                r;
        logic                   is_dig;
        logic                   closed;
        longint unsigned        grown;
        logic [NUMBER_BITS-1:0] num;

        r      = '0;
        closed = 1'b0;
        is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
        grown  = 64'(acc_num) * 64'd10 + 64'(b[3:0]);

        if (prs_phase == PH_PAYLOAD) begin
            // After the header a missing byte is simply consumed.
            if (at_end) begin
                r.kind = K_CONSUMED;
            end else begin
                r.kind  = K_PAYLOAD;
                r.value = {24'd0, b};
            end
            return r;
        end
        if (prs_phase == PH_ERROR || at_end) begin
            return latch_fault();
        end

        if (prs_phase == PH_TOTAL || prs_phase == PH_LEN || prs_phase == PH_COUNT) begin
            if (b != SEP_NUMBER) begin
                if (!is_dig || grown > NUM_LIMIT) begin
                    return latch_fault();
                end
                acc_num   = grown[NUMBER_BITS-1:0];
                has_digit = 1'b1;
                r.kind    = K_CONSUMED;
                return r;
            end
            // A separator with no digit before it is an empty number.
            if (!has_digit) begin
                return latch_fault();
            end
            num       = acc_num;
            acc_num   = '0;
            has_digit = 1'b0;
            if (prs_phase == PH_TOTAL) begin
                prs_phase = PH_LEN;
                r.kind    = K_TOTAL;
                r.value   = 32'(num) - 32'd1;
            end else if (prs_phase == PH_LEN) begin
                tbl_bytes = num;
                prs_phase = PH_COUNT;
                r.kind    = K_LEN;
                r.value   = 32'(num);
            end else begin
                ent_pending  = num;
                ent_reported = '0;
                if (tbl_bytes == '0) begin
                    // An empty table is only legal when no entries are promised.
                    if (num != '0) begin
                        return latch_fault();
                    end
                    prs_phase = PH_PAYLOAD;
                    r.kind    = K_DONE;
                    r.value   = '1;
                end else begin
                    prs_phase = PH_SYM;
                    r.kind    = K_COUNT;
                    r.value   = 32'(num);
                end
            end
            return r;
        end

        // Table bytes from here on.
        if (tbl_bytes == '0) begin
            return latch_fault();
        end
        tbl_bytes = tbl_bytes - NUMBER_BITS'(1);

        if (prs_phase == PH_SYM) begin
            // Once every entry is in, leftover table bytes are only counted off.
            if (ent_pending != '0) begin
                sym_hold  = b;
                has_digit = 1'b0;
                lead_run  = 1'b0;
                acc_num   = '0;
                prs_phase = PH_DIGITS;
            end
        end else if (!has_digit) begin
            if (!is_dig) begin
                return latch_fault();
            end
            acc_num   = NUMBER_BITS'(b[3:0]);
            has_digit = 1'b1;
            lead_run  = 1'b1;
        end else if (b == SEP_ENTRY) begin
            closed        = 1'b1;
            r.value       = 32'(acc_num);
            r.symbol      = sym_hold;
            r.entry_index = ent_reported;
            ent_reported  = ent_reported + 31'd1;
            ent_pending   = ent_pending - NUMBER_BITS'(1);
            has_digit     = 1'b0;
            lead_run      = 1'b0;
            acc_num       = '0;
            prs_phase     = PH_SYM;
        end else if (is_dig && lead_run) begin
            if (grown > NUM_LIMIT) begin
                return latch_fault();
            end
            acc_num = grown[NUMBER_BITS-1:0];
        end else begin
            // Anything after the leading digits is ignored up to the comma.
            lead_run = 1'b0;
        end

        if (tbl_bytes == '0) begin
            if (ent_pending != '0) begin
                return latch_fault();
            end
            prs_phase = PH_PAYLOAD;
            r.kind    = K_DONE;
            // The done item carries the final entry only when its comma ends the table.
            if (!closed) begin
                r.value = '1;
            end
            return r;
        end
        r.kind = closed ? K_ENTRY : K_CONSUMED;
        return r;
    endfunction

    // Offers one byte, waits for the handshake and records what it should produce.
    // The sender runs in bursts; a burst ends with a random pause on the channel.
    task automatic push_byte(input logic [7:0] b, input logic at_end);
        int gap;

        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.stream_end <= at_end;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_q.push_back(parse_byte(b, at_end));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Appends one table entry: symbol, optional leading zeros, the value's digits,
    // optional trailing bytes that the parser must skip, and the closing comma.
    task automatic append_entry(input logic [7:0] sym, input longint unsigned val,
                                input int zeros, input int tail);
        string      txt;
        logic [7:0] t;

        tbl_q.push_back(sym);
        repeat (zeros) tbl_q.push_back(CH_ZERO);
        txt = $sformatf("%0d", val);
        for (int i = 0; i < txt.len(); i++) begin
            tbl_q.push_back(txt[i]);
        end
        for (int i = 0; i < tail; i++) begin
            // The first trailing byte must end the digit run; none may be a comma.
            do begin
                t = 8'($urandom_range(0, 255));
            end while (t == SEP_ENTRY || (i == 0 && t >= CH_ZERO && t <= CH_NINE));
            tbl_q.push_back(t);
        end
        tbl_q.push_back(SEP_ENTRY);
        entries_planned++;
    endtask

    // The header announces the table's size, so the table is laid out first and
    // then the three numbers go out. Header faults are placed in or in front of
    // one of the three numbers, chosen at random.
    task automatic test_header_numbers();
        longint unsigned nums[3];
        int              tgt;
        int              zeros;
        int              shape;
        int              n_ent;
        int              bad_at;
        logic            table_fault;
        logic [7:0]      junk;
        string           txt;

        tbl_q.delete();
        entries_planned = 0;
        end_at          = -1;
        shape           = $urandom_range(0, 9);
        table_fault     = (fault >= FLT_ENTRY_NO_DIGIT);

        if (fault == FLT_EMPTY_TABLE_COUNT) begin
            decl_count = 64'($urandom_range(1, 50));
        end else if (!table_fault && shape == 0) begin
            decl_count = 0;
        end else if (fault == FLT_NONE && shape == 1) begin
            // Zero entries over a non-empty table: every table byte is spare.
            repeat ($urandom_range(1, 12)) tbl_q.push_back(8'($urandom_range(0, 255)));
            decl_count = 0;
        end else begin
            // Edge symbols (including the two separators and a digit), the largest
            // value, leading zeros and skipped trailing bytes come first.
            append_entry(8'h00, 0, 0, 0);
            append_entry(8'hFF, NUM_LIMIT, 0, 0);
            append_entry(SEP_ENTRY, 5, 2, 0);
            append_entry(SEP_NUMBER, 123, 0, 3);
            append_entry(CH_NINE, NUM_LIMIT, 3, 2);
            n_ent  = $urandom_range(15, 90);
            bad_at = $urandom_range(0, n_ent - 1);
            for (int k = 0; k < n_ent; k++) begin
                if (k == bad_at && fault == FLT_ENTRY_NO_DIGIT) begin
                    tbl_q.push_back(8'($urandom_range(0, 255)));
                    do begin
                        junk = 8'($urandom_range(0, 255));
                    end while (junk >= CH_ZERO && junk <= CH_NINE);
                    tbl_q.push_back(junk);
                end else if (k == bad_at && fault == FLT_ENTRY_OVERFLOW) begin
                    append_entry(8'($urandom_range(0, 255)),
                                 NUM_LIMIT + 64'd1 + 64'($urandom), 0, 0);
                end else begin
                    append_entry(8'($urandom_range(0, 255)),
                                 ($urandom_range(0, 3) == 0) ?
                                     64'($urandom_range(32'h7FFF_FFFF, 0)) :
                                     64'($urandom_range(0, 999)),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                end
            end
            decl_count = 64'(entries_planned);
            if (fault == FLT_TABLE_OVERRUN) begin
                decl_count++;
            end
            // Spare bytes after the last entry; without them its comma ends the table.
            if (fault == FLT_NONE && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 6)) tbl_q.push_back(8'($urandom_range(0, 255)));
            end
        end

        decl_len = 64'(tbl_q.size());
        if (fault == FLT_OPEN_ENTRY_OVERRUN) begin
            // Cut the length so the table ends inside its last entry.
            decl_len -= 64'($urandom_range(1, 2));
        end
        if (fault == FLT_TABLE_END) begin
            end_at = $urandom_range(0, tbl_q.size() - 1);
        end

        case ($urandom_range(0, 3))
            0:       nums[0] = 0;
            1:       nums[0] = NUM_LIMIT;
            default: nums[0] = 64'($urandom_range(1, 5000));
        endcase
        nums[1] = decl_len;
        nums[2] = decl_count;
        tgt     = $urandom_range(0, 2);

        for (int k = 0; k < 3; k++) begin
            if (k == tgt) begin
                case (fault)
                    FLT_BAD_HEADER_BYTE: begin
                        do begin
                            junk = 8'($urandom_range(0, 255));
                        end while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == SEP_NUMBER);
                        push_byte(junk, 1'b0);
                    end
                    FLT_EMPTY_NUMBER: begin
                        push_byte(SEP_NUMBER, 1'b0);
                    end
                    FLT_HEADER_OVERFLOW: begin
                        nums[k] = NUM_LIMIT + 64'd1 + 64'($urandom);
                    end
                    FLT_HEADER_END: begin
                        push_byte(8'($urandom_range(0, 255)), 1'b1);
                    end
                    default: begin
                    end
                endcase
            end
            zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            repeat (zeros) push_byte(CH_ZERO, 1'b0);
            txt = $sformatf("%0d", nums[k]);
            for (int i = 0; i < txt.len(); i++) begin
                push_byte(txt[i], 1'b0);
            end
            push_byte(SEP_NUMBER, 1'b0);
        end
    endtask

    // Sends the planned table, with an early end of stream where the fault asks.
    task automatic test_frequency_table();
        for (int i = 0; i < tbl_q.size(); i++) begin
            if (i == end_at) begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            push_byte(tbl_q[i], 1'b0);
        end
    endtask

    // Everything after the header: byte extremes first, then random bytes with an
    // occasional end of stream. After a fault these all check that the error holds.
    task automatic test_payload_pass();
        int n_rest;

        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(SEP_NUMBER, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        n_rest = (items_sent < STREAM_ITEMS - 100) ? STREAM_ITEMS - items_sent : 100;
        repeat (n_rest) begin
            push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end
    endtask

    // Receiver: each stretch is either always ready, ready at random, or ready on a
    // rotating bit pattern, so stalls land on every phase of the parse.
    initial begin
        out_ch.ready <= 1'b0;
        rx_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode    = $urandom_range(0, 2);
                rx_left    = $urandom_range(16, 96);
                rx_pattern = $urandom | 32'd1;
            end
            rx_left--;
            rx_pattern = {rx_pattern[30:0], rx_pattern[31]};
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= rx_pattern[0];
            endcase
        end
    end

    // Every result taken from the block is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: kind %0d", out_ch.kind);
                err_count++;
            end else begin
                exp_r = expected_q.pop_front();
                results_checked++;
                kind_tally[out_ch.kind]++;
                if (out_ch.kind !== exp_r.kind) begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, out_ch.kind);
                    err_count++;
                end
                if (out_ch.value !== exp_r.value) begin
                    $error("value: expected %0d, actual %0d",
                           $signed(exp_r.value), out_ch.value);
                    err_count++;
                end
                if (out_ch.symbol !== exp_r.symbol) begin
                    $error("symbol: expected %0d, actual %0d", exp_r.symbol, out_ch.symbol);
                    err_count++;
                end
                if (out_ch.entry_index !== exp_r.entry_index) begin
                    $error("entry_index: expected %0d, actual %0d",
                           exp_r.entry_index, out_ch.entry_index);
                    err_count++;
                end
            end
        end
    end

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'h00;
        in_ch.stream_end <= 1'b0;
        i_rst_n          <= 1'b0;
        err_count       = 0;
        items_sent      = 0;
        results_checked = 0;
        foreach (kind_tally[i]) kind_tally[i] = 0;

        // Half the runs are clean; the rest carry one fault picked by the seed.
        if ($urandom_range(0, 1) == 0) begin
            fault = FLT_NONE;
        end else begin
            fault = fault_e'($urandom_range(FLT_TABLE_END, FLT_BAD_HEADER_BYTE));
        end

        prs_phase    = PH_TOTAL;
        acc_num      = '0;
        has_digit    = 1'b0;
        lead_run     = 1'b0;
        tbl_bytes    = '0;
        ent_pending  = '0;
        ent_reported = '0;
        sym_hold     = '0;
        burst_left   = $urandom_range(0, 15);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_numbers();
        test_frequency_table();
        test_payload_pass();

        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // A further wait after the queue empties catches any extra results.
        repeat (8) @(posedge i_clk);

        $display("Parsed a %0d-byte table with %0d entries planned, fault scenario %s.",
                 tbl_q.size(), entries_planned, fault.name());
        $display("Checked %0d results over %0d bytes: %0d entries, %0d payload, %0d error.",
                 results_checked, items_sent, kind_tally[K_ENTRY], kind_tally[K_PAYLOAD],
                 kind_tally[K_ERROR]);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard limit, far above the slowest legal run of about a thousand items.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/fhp_pkg.sv
rtl/core/fhp_if.sv
rtl/core/fhp_step.sv
rtl/core/frequency_header_parser.sv
test/frequency_header_parser_tb.sv
